/* rtl/raa_pkg.sv */
`default_nettype none
package raa_pkg;
	localparam int CW = 16;
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_ALLOC  = 1'b1;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [CW-1:0] h;
		logic [CW-1:0] w;
		logic [CW-1:0] y;
		logic [CW-1:0] x;
	} rect_t;

	typedef struct packed {
		logic      func;
		logic [CW-1:0] rect_x;
		logic [CW-1:0] rect_y;
		logic [CW-1:0] rect_w;
		logic [CW-1:0] rect_h;
	} req_t;

	typedef struct packed {
		logic [CW-1:0] out_x;
		logic [CW-1:0] out_y;
		logic [CW-1:0] out_w;
		logic [CW-1:0] out_h;
		logic [1:0]    status;
	} rsp_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		OP_HOLD, OP_APPEND, OP_SHL, OP_SHR, OP_WRITE
	} op_t;

	typedef struct packed {
		op_t   op;
		rect_t data;
	} cell_cmd_t;
endpackage
`default_nettype wire

/* rtl/raa_if.sv */
`default_nettype none
interface raa_req_if;
	logic valid;
	logic ready;
	raa_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface raa_rsp_if;
	logic valid;
	logic ready;
	raa_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/raa_cell.sv */
`default_nettype none
// One list slot. Shifts left/right with its neighbors, takes appends at the
// tail, and takes a point write; reports degenerate and fit flags.
module raa_cell #(
	parameter int IDX_BITS = 6
) (
	input  wire                  clk,
	input  wire raa_pkg::cell_cmd_t cmd,
	input  wire [IDX_BITS-1:0]   my_idx,
	input  wire [IDX_BITS-1:0]   sel_idx,
	input  wire [IDX_BITS:0]     count,
	input  wire raa_pkg::rect_t  left_in,
	input  wire raa_pkg::rect_t  right_in,
	input  wire [raa_pkg::CW-1:0] req_w,
	input  wire [raa_pkg::CW-1:0] req_h,
	output raa_pkg::rect_t       q,
	output logic                 degen,
	output logic                 fits
);
	import raa_pkg::*;
	rect_t e_q;
	logic  at_or_after;

	assign at_or_after = (my_idx >= sel_idx);
	assign q     = e_q;
	assign degen = (e_q.w == '0) || (e_q.h == '0);
	assign fits  = (e_q.w >= req_w) && (e_q.h >= req_h);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_APPEND: if ({1'b0, my_idx} == count) e_q <= cmd.data;
			OP_SHL:    if (at_or_after) e_q <= right_in;
			OP_SHR:    if (my_idx == '0) e_q <= cmd.data; else e_q <= left_in;
			OP_WRITE:  if (my_idx == sel_idx) e_q <= cmd.data;
			default:   ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/rectangle_atlas_allocator_unit.sv */
`default_nettype none
// Channel | Dir | Payload
// req     | in  | func, rect_x, rect_y, rect_w, rect_h
// rsp     | out | out_x, out_y, out_w, out_h, status
// Append: result valid in the cycle after the beat is taken. Allocate: the
// beat goes to S_SCAN, which removes one degenerate entry ahead of the match
// per shift, then S_SHR does the front insertion after a guillotine cut, then
// S_OUT; the chain of cells does one shift per cycle.
// One item at a time; reset empties the list, entries need no clearing.
// The result register holds while rsp.ready is low; no item is taken then.
module rectangle_atlas_allocator_unit #(
	parameter int MAX_FREE   = 64,
	parameter int COORD_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	raa_req_if.sink   req,
	raa_rsp_if.source rsp
);
	import raa_pkg::*;
	localparam int IB = $clog2(MAX_FREE);
	localparam logic [IB:0] MAXC = (IB+1)'(MAX_FREE);
	localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_SPLIT = 3'd2,
		S_SHR = 3'd3, S_OUT = 3'd4;

	logic [2:0]    st_q;
	logic [IB:0]   cnt_q;
	req_t          r_q;
	rsp_t          o_q;
	rect_t         pend_q;
	cell_cmd_t     cmd;
	logic [IB-1:0] sel;
	rect_t         cq [MAX_FREE];
	logic [MAX_FREE-1:0] dg, ft, lv;
	logic [CW-1:0] cmask;
	logic          hit;
	logic [IB-1:0] hidx;
	logic          hdeg;

	assign cmask = CW'((32'd1 << COORD_BITS) - 1);

	genvar g;
	generate
		for (g = 0; g < MAX_FREE; g++) begin : g_cell
			raa_cell #(.IDX_BITS(IB)) u_cell (
				.clk(clk), .cmd(cmd), .my_idx(IB'(g)), .sel_idx(sel),
				.count(cnt_q),
				.left_in(cq[(g + MAX_FREE - 1) % MAX_FREE]),
				.right_in(cq[(g + 1) % MAX_FREE]),
				.req_w(r_q.rect_w), .req_h(r_q.rect_h),
				.q(cq[g]), .degen(dg[g]), .fits(ft[g]));
			assign lv[g] = (IB+1)'(g) < cnt_q;
		end
	endgenerate

	// First live entry that is degenerate or fits (priority from the head).
	always_comb begin
		hit = 1'b0; hidx = '0; hdeg = 1'b0;
		for (int k = MAX_FREE-1; k >= 0; k--) begin
			if (lv[k] && (dg[k] || ft[k])) begin
				hit = 1'b1; hidx = IB'(k); hdeg = dg[k];
			end
		end
	end

	rect_t e;
	assign e = cq[hidx];
	logic eqw, eqh;
	assign eqw = e.w == r_q.rect_w;
	assign eqh = e.h == r_q.rect_h;
	rsp_t hit_rsp;
	assign hit_rsp = '{out_x: e.x, out_y: e.y, out_w: eqw ? e.w : r_q.rect_w,
		out_h: eqh ? e.h : r_q.rect_h, status: ST_OK};

	always_comb begin
		cmd = '{op: OP_HOLD, data: '0};
		sel = hidx;
		if (st_q == S_IDLE && req.valid && req.ready && req.payload.func == FUNC_APPEND
				&& cnt_q < MAXC) begin
			cmd.op = OP_APPEND;
			cmd.data = '{h: req.payload.rect_h & cmask, w: req.payload.rect_w & cmask,
				y: req.payload.rect_y & cmask, x: req.payload.rect_x & cmask};
		end else if (st_q == S_SCAN && hit && (hdeg || (eqw && eqh))) begin
			cmd.op = OP_SHL;
		end else if (st_q == S_SCAN && hit && (eqw || eqh || cnt_q < MAXC)) begin
			cmd.op = OP_WRITE;
			if (eqw) cmd.data = '{h: (e.h - r_q.rect_h) & cmask, w: e.w,
				y: (e.y + r_q.rect_h) & cmask, x: e.x};
			else cmd.data = '{h: e.h, w: (e.w - r_q.rect_w) & cmask,
				y: e.y, x: (e.x + r_q.rect_w) & cmask};
		end else if (st_q == S_SHR) begin
			cmd.op = OP_SHR;
			cmd.data = pend_q;
		end
	end

	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = (st_q == S_OUT);
	assign rsp.payload = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (req.valid) begin
					r_q <= req.payload;
					if (req.payload.func == FUNC_APPEND) begin
						if (cnt_q < MAXC) begin
							cnt_q <= cnt_q + 1'b1;
							o_q <= '0;
						end else begin
							o_q <= '{out_x: '0, out_y: '0, out_w: '0, out_h: '0,
								status: ST_FULL};
						end
						st_q <= S_OUT;
					end else begin
						o_q <= '0;
						st_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!hit) begin
						o_q.status <= ST_NOFIT; st_q <= S_OUT;
					end else if (hdeg) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (eqw && eqh) begin
						o_q <= hit_rsp;
						cnt_q <= cnt_q - 1'b1; st_q <= S_OUT;
					end else if (eqw || eqh) begin
						o_q <= hit_rsp; st_q <= S_OUT;
					end else if (cnt_q >= MAXC) begin
						// The result register is still zero from the request beat.
						o_q.status <= ST_FULL; st_q <= S_OUT;
					end else begin
						o_q <= hit_rsp;
						pend_q <= '{h: (e.h - r_q.rect_h) & cmask, w: r_q.rect_w,
							y: (e.y + r_q.rect_h) & cmask, x: e.x};
						st_q <= S_SHR;
					end
				end
				S_SHR: begin
					cnt_q <= cnt_q + 1'b1; st_q <= S_OUT;
				end
				S_OUT: if (rsp.ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/raa_checker.sv */
`default_nettype none
module raa_checker (
	input wire clk,
	input wire arst_n,
	input wire req_valid,
	input wire req_ready,
	input wire rsp_valid,
	input wire rsp_ready,
	input wire [1:0] rsp_status,
	input wire [15:0] rsp_w
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("input taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != 2'd0 |-> rsp_w == 16'd0) else $error("fail nonzero");
endmodule

bind rectangle_atlas_allocator_unit raa_checker u_raa_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.payload.status), .rsp_w(rsp.payload.out_w));
`default_nettype wire
